// ----- design/wsfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  typedef enum logic [2:0] {
    PH_HDR0     = 3'd0,
    PH_HDR1     = 3'd1,
    PH_HDR1_RSV = 3'd2,
    PH_EXT      = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
  localparam logic [1:0] KIND_RSV_ERROR = 2'd2;
  localparam logic [1:0] KIND_MASK_ERROR = 2'd3;

  localparam logic [7:0]  RESERVED_MASK = 8'h70;
  localparam logic [6:0]  LEN16_CODE    = 7'd126;
  localparam logic [3:0]  EXT_BYTES_16  = 4'd2;
  localparam logic [3:0]  EXT_BYTES_64  = 4'd8;
  localparam logic [3:0]  OPCODE_CLOSE  = 4'd8;
  localparam logic [15:0] CLOSE_NORMAL  = 16'd1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic [63:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] close_reply_code;
  } result_t;

endpackage

// ----- design/wsfp_skid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfp_skid
// Two-entry output buffer: a result register plus one skid register.
// ----------------------------------------------------------------------------
module wsfp_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  wsfp_pkg::result_t in_res,
  output logic             out_valid,
  input  logic             out_stall,
  output wsfp_pkg::result_t out_res
);

  logic              main_valid;
  logic              skid_valid;
  wsfp_pkg::result_t main_res;
  wsfp_pkg::result_t skid_res;
  logic              push;
  logic              pop;

  assign in_stall  = skid_valid;
  assign push      = in_valid && !skid_valid;
  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res   <= in_res;
        main_valid <= 1'b1;
      end else begin
        skid_res   <= in_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

// ----- design/websocket_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Receive-side parser for an unmasked WebSocket frame byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per request on rx_byte, taken when
//   in_valid is high and in_stall is low.
//   Output channel: at most one result per input byte (header done, payload
//   byte, reserved flag error or masked frame error), taken when out_valid
//   is high and out_stall is low. Header bytes before the last length byte
//   produce no result.
//   Each result is registered, in the result register or the skid register.
//   Throughput: one byte per cycle while in_stall is low; the per-byte work is a single
//   pass through the header/length/payload decode between the phase
//   registers and the result register.
//   Stall: results go into a result register backed by one skid register,
//   so a byte can still be taken while a result waits. in_stall rises only
//   when both are occupied and clears once the receiver takes one.
//   Reset: synchronous, active high. The parser waits for the first header
//   byte and the output buffer is empty. After an error the parser again
//   waits for a new header.
// ----------------------------------------------------------------------------
module websocket_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        fin_flag,
  output logic [3:0]  frame_opcode,
  output logic [63:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        last,
  output logic [15:0] close_reply_code
);

  // Parser state
  wsfp_pkg::phase_t phase, phase_next;
  logic        fin_reg, fin_reg_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic [3:0]  ext_bytes_left, ext_bytes_left_next;
  logic [63:0] length_accum, length_accum_next;
  logic [63:0] payload_left, payload_left_next;
  logic [7:0]  close_high_byte, close_high_byte_next;
  logic [7:0]  close_low_byte, close_low_byte_next;
  logic [1:0]  close_bytes_seen, close_bytes_seen_next;

  logic              accept;
  logic              res_valid;
  wsfp_pkg::result_t res;
  wsfp_pkg::result_t out_res;

  // Decode helpers
  logic        rsv_hit;
  logic [6:0]  len7;
  logic        short_len;
  logic [63:0] ext_accum;
  logic [3:0]  ext_left_dec;
  logic        is_close;
  logic        pay_last;

  assign accept       = in_valid && !in_stall;
  assign rsv_hit      = |(rx_byte & wsfp_pkg::RESERVED_MASK);
  assign len7         = rx_byte[6:0];
  assign short_len    = len7 < wsfp_pkg::LEN16_CODE;
  assign ext_accum    = {length_accum[55:0], rx_byte};
  assign ext_left_dec = ext_bytes_left - 4'd1;
  assign is_close     = opcode_reg == wsfp_pkg::OPCODE_CLOSE;
  assign pay_last     = payload_left == 64'd1;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      wsfp_pkg::PH_HDR0: begin
        phase_next = rsv_hit ? wsfp_pkg::PH_HDR1_RSV : wsfp_pkg::PH_HDR1;
      end
      wsfp_pkg::PH_HDR1_RSV: begin
        phase_next = wsfp_pkg::PH_HDR0;
      end
      wsfp_pkg::PH_HDR1: begin
        if (rx_byte[7]) begin
          phase_next = wsfp_pkg::PH_HDR0;
        end else if (short_len) begin
          phase_next = (len7 == 7'd0) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_PAYLOAD;
        end else begin
          phase_next = wsfp_pkg::PH_EXT;
        end
      end
      wsfp_pkg::PH_EXT: begin
        if (ext_left_dec == 4'd0) begin
          phase_next = (ext_accum == 64'd0) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_PAYLOAD;
        end
      end
      wsfp_pkg::PH_PAYLOAD: begin
        if (pay_last) begin
          phase_next = wsfp_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_next = wsfp_pkg::PH_HDR0;
      end
    endcase
  end

  // Datapath and result
  always_comb begin
    fin_reg_next          = fin_reg;
    opcode_reg_next       = opcode_reg;
    ext_bytes_left_next   = ext_bytes_left;
    length_accum_next     = length_accum;
    payload_left_next     = payload_left;
    close_high_byte_next  = close_high_byte;
    close_low_byte_next   = close_low_byte;
    close_bytes_seen_next = close_bytes_seen;
    res_valid             = 1'b0;
    res.kind              = wsfp_pkg::KIND_HEADER;
    res.fin_flag          = fin_reg;
    res.frame_opcode      = opcode_reg;
    res.payload_length    = 64'd0;
    res.data_byte         = 8'd0;
    res.last              = 1'b0;
    res.close_reply_code  = 16'd0;
    unique case (phase)
      wsfp_pkg::PH_HDR0: begin
        fin_reg_next    = rx_byte[7];
        opcode_reg_next = rx_byte[3:0];
      end
      wsfp_pkg::PH_HDR1_RSV: begin
        res_valid = 1'b1;
        res.kind  = wsfp_pkg::KIND_RSV_ERROR;
      end
      wsfp_pkg::PH_HDR1: begin
        if (rx_byte[7]) begin
          res_valid = 1'b1;
          res.kind  = wsfp_pkg::KIND_MASK_ERROR;
        end else if (short_len) begin
          // 7-bit length: header is complete now
          length_accum_next     = {57'd0, len7};
          payload_left_next     = {57'd0, len7};
          close_bytes_seen_next = 2'd0;
          close_high_byte_next  = 8'd0;
          close_low_byte_next   = 8'd0;
          res_valid             = 1'b1;
          res.payload_length    = {57'd0, len7};
          if (len7 == 7'd0) begin
            res.last             = 1'b1;
            res.close_reply_code = is_close ? wsfp_pkg::CLOSE_NORMAL : 16'd0;
          end
        end else begin
          length_accum_next   = 64'd0;
          ext_bytes_left_next = (len7 == wsfp_pkg::LEN16_CODE) ?
                                wsfp_pkg::EXT_BYTES_16 : wsfp_pkg::EXT_BYTES_64;
        end
      end
      wsfp_pkg::PH_EXT: begin
        length_accum_next   = ext_accum;
        ext_bytes_left_next = ext_left_dec;
        if (ext_left_dec == 4'd0) begin
          payload_left_next     = ext_accum;
          close_bytes_seen_next = 2'd0;
          close_high_byte_next  = 8'd0;
          close_low_byte_next   = 8'd0;
          res_valid             = 1'b1;
          res.payload_length    = ext_accum;
          if (ext_accum == 64'd0) begin
            res.last             = 1'b1;
            res.close_reply_code = is_close ? wsfp_pkg::CLOSE_NORMAL : 16'd0;
          end
        end
      end
      wsfp_pkg::PH_PAYLOAD: begin
        // first two payload bytes hold the close code
        if (close_bytes_seen == 2'd0) begin
          close_high_byte_next  = rx_byte;
          close_bytes_seen_next = 2'd1;
        end else if (close_bytes_seen == 2'd1) begin
          close_low_byte_next   = rx_byte;
          close_bytes_seen_next = 2'd2;
        end
        payload_left_next  = payload_left - 64'd1;
        res_valid          = 1'b1;
        res.kind           = wsfp_pkg::KIND_PAYLOAD;
        res.payload_length = length_accum;
        res.data_byte      = rx_byte;
        res.last           = pay_last;
        if (pay_last && is_close) begin
          res.close_reply_code = (close_bytes_seen_next >= 2'd2) ?
                                 {close_high_byte_next, close_low_byte_next} :
                                 wsfp_pkg::CLOSE_NORMAL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wsfp_pkg::PH_HDR0;
      fin_reg          <= 1'b0;
      opcode_reg       <= 4'd0;
      ext_bytes_left   <= 4'd0;
      length_accum     <= 64'd0;
      payload_left     <= 64'd0;
      close_high_byte  <= 8'd0;
      close_low_byte   <= 8'd0;
      close_bytes_seen <= 2'd0;
    end else if (accept) begin
      phase            <= phase_next;
      fin_reg          <= fin_reg_next;
      opcode_reg       <= opcode_reg_next;
      ext_bytes_left   <= ext_bytes_left_next;
      length_accum     <= length_accum_next;
      payload_left     <= payload_left_next;
      close_high_byte  <= close_high_byte_next;
      close_low_byte   <= close_low_byte_next;
      close_bytes_seen <= close_bytes_seen_next;
    end
  end

  wsfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_stall  (in_stall),
    .in_res    (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind             = out_res.kind;
  assign fin_flag         = out_res.fin_flag;
  assign frame_opcode     = out_res.frame_opcode;
  assign payload_length   = out_res.payload_length;
  assign data_byte        = out_res.data_byte;
  assign last             = out_res.last;
  assign close_reply_code = out_res.close_reply_code;

endmodule
